FILE: hdl/sorted_priority_queue_core_macros.svh
// ============================================================================
// Sorted priority queue assertion macros
// Concurrent assertion shorthands shared by the queue RTL; they compile to
// nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/spq_pkg.sv
// ============================================================================
// Sorted priority queue package
// Field widths, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package spq_pkg;

    // Field widths
    localparam int ELEM_W    = 32;
    localparam int PRIO_W    = 16;
    localparam int OCC_W     = 5;
    localparam int ENTRY_W   = ELEM_W + PRIO_W;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // Operation codes carried on the input tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch the accepted word, clear the result
        logic ovf;        // mark overflow
        logic udf;        // mark underflow
        logic start_ins;  // point at the tail and read it
        logic rd_head;    // read the front entry
        logic shift;      // move the entry read back by one slot, step down
        logic k_inc;      // step the walk pointer up by one
        logic put;        // write the new entry at the walk pointer
        logic pop;        // take the front entry out
        logic out_load;   // load the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic k_zero;
        logic greater;    // entry read has a larger priority than the new one
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: hdl/spq_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents on a clash
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/spq_dp.sv
// ============================================================================
// Sorted priority queue datapath
// Circular entry store with head and live count, the insertion walk pointer,
// the latched word and the output register.
// ============================================================================
`default_nettype none
`include "sorted_priority_queue_core_macros.svh"

module spq_dp #(
    parameter int CAPACITY = 16,
    localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire spq_pkg::cmd_t                   cmd,
    output spq_pkg::stat_t                       stat,
    input  wire logic [spq_pkg::S_TDATA_W-1:0]   in_tdata,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic      [spq_pkg::M_TDATA_W-1:0]   out_tdata,
    output logic      [1:0]                      out_tuser
);

    localparam int EW = spq_pkg::ELEM_W;
    localparam int PW = spq_pkg::PRIO_W;
    localparam int OW = spq_pkg::OCC_W;
    localparam int PAD_W = spq_pkg::M_TDATA_W - EW - PW - OW;

    // Map a queue offset to a slot of the circular store
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] offset);
        logic [AW:0] sum;
        begin
            sum = {1'b0, head} + {1'b0, offset};
            if (sum >= (AW+1)'(CAPACITY))
            begin
                sum = sum - (AW+1)'(CAPACITY);
            end
            return sum[AW-1:0];
        end
    endfunction

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    logic [EW-1:0]      elem_reg;
    logic [PW-1:0]      prio_reg;
    spq_pkg::status_t   status_reg;
    logic [EW-1:0]      rem_elem_reg;
    logic [PW-1:0]      rem_prio_reg;
    spq_pkg::status_t   out_status_reg;
    logic [EW-1:0]      out_elem_reg;
    logic [PW-1:0]      out_prio_reg;
    logic [OW-1:0]      out_occ_reg;

    logic                          rd_en, wr_en;
    logic [AW-1:0]                 rd_addr, wr_addr;
    logic [spq_pkg::ENTRY_W-1:0]   rd_data, wr_data;
    logic [EW-1:0]                 rd_elem;
    logic [PW-1:0]                 rd_prio;
    logic                          k_zero;
    logic                          empty;

    assign rd_elem = rd_data[EW-1:0];
    assign rd_prio = rd_data[EW +: PW];
    assign k_zero  = (k_reg == '0);
    assign empty   = (count_reg == '0);

    // Report status to the controller
    assign stat.empty    = empty;
    assign stat.full     = (count_reg == CW'(CAPACITY));
    assign stat.k_zero   = k_zero;
    assign stat.greater  = ($signed(rd_prio) > $signed(prio_reg));
    assign stat.out_free = !out_valid_reg || out_ready;

    // Steer the store ports
    always_comb
    begin
        rd_en   = cmd.rd_head || (cmd.start_ins && !empty) || (cmd.shift && !k_zero);
        rd_addr = head_reg;
        wr_en   = cmd.shift || cmd.put;
        wr_addr = phys(head_reg, k_reg);
        wr_data = {prio_reg, elem_reg};
        priority if (cmd.start_ins)
        begin
            rd_addr = phys(head_reg, AW'(count_reg - CW'(1)));
        end
        else if (cmd.shift)
        begin
            rd_addr = phys(head_reg, k_reg - AW'(1));
            wr_addr = phys(head_reg, k_reg + AW'(1));
            wr_data = rd_data;
        end
    end

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Advance head, count, walk pointer and output valid
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (cmd.pop)
        begin
            head_next  = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
        if (cmd.put)
        begin
            count_next = count_reg + CW'(1);
        end
        priority if (cmd.start_ins)
        begin
            k_next = empty ? '0 : AW'(count_reg - CW'(1));
        end
        else if (cmd.shift && !k_zero)
        begin
            k_next = k_reg - AW'(1);
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + AW'(1);
        end
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the word and build the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            elem_reg     <= in_tdata[EW-1:0];
            prio_reg     <= in_tdata[EW +: PW];
            rem_elem_reg <= '0;
            rem_prio_reg <= '0;
            // Mark overflow or underflow, else clear the status
            priority if (cmd.udf)
            begin
                status_reg <= spq_pkg::STATUS_UNDERFLOW;
            end
            else if (cmd.ovf)
            begin
                status_reg <= spq_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                status_reg <= spq_pkg::STATUS_OK;
            end
        end
        if (cmd.pop)
        begin
            rem_elem_reg <= rd_elem;
            rem_prio_reg <= rd_prio;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_elem_reg   <= rem_elem_reg;
            out_prio_reg   <= rem_prio_reg;
            out_occ_reg    <= OW'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tdata = {{PAD_W{1'b0}}, out_occ_reg, out_prio_reg, out_elem_reg};
    assign out_tuser = out_status_reg;

    `SPQ_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "live count above capacity")
    `SPQ_ASSERT_IMPLY(a_put_not_full, clk, rst_n, cmd.put, count_reg != CW'(CAPACITY), "write into a full queue")
    `SPQ_ASSERT_IMPLY(a_pop_not_empty, clk, rst_n, cmd.pop, !empty, "pop from an empty queue")
    `SPQ_ASSERT_NEXT(a_pop_count, clk, rst_n, cmd.pop, count_reg == $past(count_reg) - CW'(1), "pop did not drop the count")
    `SPQ_ASSERT_IMPLY(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "result overwrote a waiting word")

endmodule

`default_nettype wire

FILE: hdl/spq_ctrl.sv
// ============================================================================
// Sorted priority queue controller
// Sequences accept, insertion walk, front removal and result hand-off.
// ============================================================================
`default_nettype none

module spq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_func,
    output logic                in_ready,
    input  wire spq_pkg::stat_t stat,
    output spq_pkg::cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INS  = 5'b00010,
        ST_PUT  = 5'b00100,
        ST_DEL  = 5'b01000,
        ST_DLV  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_func == spq_pkg::FUNC_DELETE)
                    begin
                        if (stat.empty)
                        begin
                            cmd.udf    = 1'b1;
                            state_next = ST_DLV;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = ST_DEL;
                        end
                    end
                    else if (stat.full)
                    begin
                        cmd.ovf    = 1'b1;
                        state_next = ST_DLV;
                    end
                    else
                    begin
                        cmd.start_ins = 1'b1;
                        state_next    = stat.empty ? ST_PUT : ST_INS;
                    end
                end
            end
            ST_INS:
            begin
                // Move larger entries up one slot until the new one fits
                if (stat.greater)
                begin
                    cmd.shift = 1'b1;
                    if (stat.k_zero)
                    begin
                        state_next = ST_PUT;
                    end
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = ST_DLV;
            end
            ST_DEL:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_DLV;
            end
            ST_DLV:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue_core.sv
// An overflow or underflow goes straight to the result hand-off, a delete first pops
// the front entry, and an insert walks down from the tail, moving larger entries up, then writes the new entry.
// Throughput: one word at a time; the next word is taken once the result is in
// the output register. The insertion walk moves one entry a cycle through the
// single write port of the entry RAM. Reset clears the controller, head, count
// and output valid; the entry RAM is not cleared and needs no clearing pass.
// ============================================================================
// Sorted priority queue core
// Bounded priority queue kept sorted by ascending priority in a circular RAM,
// with stream ports for requests and results.
// ============================================================================
`default_nettype none

module sorted_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // element [31:0], priority_req [47:32]
    input  wire logic [spq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func [0]
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // removed_element [31:0], removed_priority [47:32], occupancy [52:48]
    output logic      [spq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic      [1:0]                    m_axis_tuser
);

    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_tdata  (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives insert and delete words through the request stream and checks every
// result word against a local model of the sorted queue or, for checked rows, the
// directed table. A short table of directed words covers empty, full, tied and
// extreme priorities. Random traffic then runs in phases that lean toward inserts
// or deletes, so the queue fills and empties many times. Sender bursts and receiver
// stalls vary throughout, with two long receiver hold-offs and a mid-run drain pause.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEM_W    = spq_pkg::ELEM_W;
    localparam int PRIO_W    = spq_pkg::PRIO_W;
    localparam int OCC_W     = spq_pkg::OCC_W;
    localparam int S_TDATA_W = spq_pkg::S_TDATA_W;
    localparam int M_TDATA_W = spq_pkg::M_TDATA_W;

    localparam int QCAP        = 16;
    localparam int RAND_ITEMS  = 1900;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    // One result word, split into its fields
    typedef struct packed {
        spq_pkg::status_t   status;
        logic [ELEM_W-1:0]  rem_elem;
        logic [PRIO_W-1:0]  rem_prio;
        logic [OCC_W-1:0]   occ;
    } result_t;

    // One row of the directed table; want is used only when chk is set
    typedef struct packed {
        logic               func;
        logic [ELEM_W-1:0]  elem;
        logic [PRIO_W-1:0]  prio;
        logic               chk;
        result_t            want;
    } stim_row_t;

    localparam result_t NO_RESULT = '{spq_pkg::STATUS_OK, 32'h0, 16'h0, 5'd0};
    localparam int DIR_ROWS = 27;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    // Queue model state
    logic [ELEM_W-1:0]        model_elem [QCAP];
    logic signed [PRIO_W-1:0] model_prio [QCAP];
    int                       model_count;

    result_t pending_results [$];
    int      mismatch_count;
    int      idle_cycles = 0;
    int      burst_left;
    bit      no_gaps;
    int      hold_reqs;

    stim_row_t dir_table [DIR_ROWS] = '{
        // delete on an empty queue
        '{spq_pkg::FUNC_DELETE, 32'h00000000, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_UNDERFLOW, 32'h0, 16'h0, 5'd0}},
        // extremes of element and priority
        '{spq_pkg::FUNC_INSERT, 32'h7FFFFFFF, 16'h7FFF, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h0, 16'h0, 5'd1}},
        '{spq_pkg::FUNC_INSERT, 32'h80000000, 16'h8000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h0, 16'h0, 5'd2}},
        '{spq_pkg::FUNC_INSERT, 32'h00000000, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h0, 16'h0, 5'd3}},
        '{spq_pkg::FUNC_INSERT, 32'hFFFFFFFF, 16'hFFFF, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h0, 16'h0, 5'd4}},
        '{spq_pkg::FUNC_DELETE, 32'h00000000, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h80000000, 16'h8000, 5'd3}},
        // equal priorities keep insertion order
        '{spq_pkg::FUNC_INSERT, 32'h11111111, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h0, 16'h0, 5'd4}},
        '{spq_pkg::FUNC_INSERT, 32'h22222222, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h0, 16'h0, 5'd5}},
        '{spq_pkg::FUNC_DELETE, 32'h00000000, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'hFFFFFFFF, 16'hFFFF, 5'd4}},
        '{spq_pkg::FUNC_DELETE, 32'h00000000, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h00000000, 16'h0000, 5'd3}},
        '{spq_pkg::FUNC_DELETE, 32'h00000000, 16'h0000, 1'b1,
          '{spq_pkg::STATUS_OK, 32'h11111111, 16'h0000, 5'd2}},
        // fill to capacity
        '{spq_pkg::FUNC_INSERT, 32'hA5A5A5A5, 16'h0040, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h5A5A5A5A, 16'h7FFF, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h00000001, 16'h8001, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'hFFFFFFFE, 16'h0040, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h12345678, 16'hFFF0, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h87654321, 16'h0100, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'hDEADBEEF, 16'h8000, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'hCAFEF00D, 16'h0001, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h0F0F0F0F, 16'h7FFE, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'hF0F0F0F0, 16'h0002, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h13579BDF, 16'h8000, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h2468ACE0, 16'hFFFF, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h7FFFFFFE, 16'h0003, 1'b0, NO_RESULT},
        '{spq_pkg::FUNC_INSERT, 32'h80000001, 16'h0004, 1'b0, NO_RESULT},
        // insert on a full queue
        '{spq_pkg::FUNC_INSERT, 32'h33333333, 16'h1234, 1'b1,
          '{spq_pkg::STATUS_OVERFLOW, 32'h0, 16'h0, 5'd16}},
        '{spq_pkg::FUNC_DELETE, 32'h00000000, 16'h0000, 1'b0, NO_RESULT}
    };

    sorted_priority_queue_core #(
        .CAPACITY(QCAP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Apply one operation to the queue model and return the result word
    function automatic result_t apply_queue_op(logic f, logic [ELEM_W-1:0] e,
                                               logic signed [PRIO_W-1:0] p);
        result_t r;
        int      pos;
        r = NO_RESULT;
        if (f == spq_pkg::FUNC_INSERT) begin
            if (model_count >= QCAP) begin
                r.status = spq_pkg::STATUS_OVERFLOW;
            end
            else begin
                // walk past every entry with a smaller or equal priority
                pos = 0;
                while (pos < model_count && model_prio[pos] <= p)
                    pos++;
                for (int i = model_count; i > pos; i--) begin
                    model_elem[i] = model_elem[i-1];
                    model_prio[i] = model_prio[i-1];
                end
                model_elem[pos] = e;
                model_prio[pos] = p;
                model_count++;
            end
        end
        else begin
            if (model_count == 0) begin
                r.status = spq_pkg::STATUS_UNDERFLOW;
            end
            else begin
                r.rem_elem = model_elem[0];
                r.rem_prio = model_prio[0];
                for (int i = 1; i < model_count; i++) begin
                    model_elem[i-1] = model_elem[i];
                    model_prio[i-1] = model_prio[i];
                end
                model_count--;
            end
        end
        r.occ = OCC_W'(model_count);
        return r;
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 4)
            return PRIO_W'(int'($urandom_range(0, 6)) - 3);  // narrow band, many ties
        else if (sel <= 7)
            return PRIO_W'($urandom);
        else if (sel == 8)
            return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        else
            return 16'h8000 + PRIO_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(15))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return 32'h00000000;
            3:       return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word in the current burst, hold it until taken, then predict
    task automatic offer(logic f, logic [ELEM_W-1:0] e, logic [PRIO_W-1:0] p,
                         logic chk, result_t want);
        result_t pred;
        int      gap;
        if (!no_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, e};
        s_axis_tuser  <= f;
        forever begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        pred = apply_queue_op(f, e, p);
        pending_results.push_back(chk ? want : pred);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Stimulus
    initial
    begin
        int item;
        int phase_len;
        int pct;
        int pressure_left;
        logic f;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = spq_pkg::FUNC_INSERT;
        model_count    = 0;
        mismatch_count = 0;
        burst_left     = 0;
        no_gaps        = 1'b0;
        hold_reqs      = 0;
        pressure_left  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (dir_table[i])
            offer(dir_table[i].func, dir_table[i].elem, dir_table[i].prio,
                  dir_table[i].chk, dir_table[i].want);
        wait_drained();

        // random phases, each leaning toward inserts or deletes
        item = 0;
        while (item < RAND_ITEMS) begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(4))
                0:       pct = 90;
                1:       pct = 65;
                2:       pct = 50;
                3:       pct = 35;
                default: pct = 10;
            endcase
            for (int k = 0; k < phase_len && item < RAND_ITEMS; k++) begin
                // long receiver hold-off with the sender pushing back to back
                if (item == 500 || item == 1300) begin
                    hold_reqs++;
                    no_gaps       = 1'b1;
                    pressure_left = 40;
                end
                if (item == 1000)
                    wait_drained();
                f = ($urandom_range(99) < pct) ? spq_pkg::FUNC_INSERT
                                               : spq_pkg::FUNC_DELETE;
                offer(f, pick_elem(), pick_prio(), 1'b0, NO_RESULT);
                if (pressure_left > 0) begin
                    pressure_left--;
                    if (pressure_left == 0)
                        no_gaps = 1'b0;
                end
                item++;
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results outstanding", 32'(pending_results.size()), 32'd0);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Receiver: stall pattern changes by mode, with a long hold on request
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        int  hold_seen;
        int  cyc;
        logic rdy;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        hold_seen     = 0;
        cyc           = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(1);
                    2:       rdy = ($urandom_range(3) == 0);
                    default: rdy = ((cyc % 7) < 4);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end
            else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[31:0] !== want.rem_elem)
                    report_mismatch("removed_element", m_axis_tdata[31:0], want.rem_elem);
                if (m_axis_tdata[47:32] !== want.rem_prio)
                    report_mismatch("removed_priority", 32'(m_axis_tdata[47:32]),
                                    32'(want.rem_prio));
                if (m_axis_tdata[52:48] !== want.occ)
                    report_mismatch("occupancy", 32'(m_axis_tdata[52:48]), 32'(want.occ));
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

FILE: sorted_priority_queue_core.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/spq_dp.sv
hdl/spq_ctrl.sv
hdl/sorted_priority_queue_core.sv
tb/tb.sv
